// ===== rtl/core/mmmv_pkg.sv =====
// ----------------------------------------------------------------------------
// mmmv_pkg
// shared constants, codes and controller/datapath interface types for the
// min/max/mean voltage tracker
// ----------------------------------------------------------------------------
package mmmv_pkg;

  localparam int ADC_BITS     = 10;
  localparam int ADC_MAX_CODE = 1023;
  localparam int COUNT_BITS   = 16;
  localparam int KEY_BITS     = 5;
  localparam int MV_BITS      = 13;

  localparam int SUM_BITS  = ADC_BITS + COUNT_BITS;
  localparam int DIVR_BITS = ADC_BITS + COUNT_BITS;
  localparam int PROD_BITS = SUM_BITS + MV_BITS;
  // quotient never exceeds full scale, so it fits the millivolt width
  localparam int QUOT_BITS = MV_BITS;
  localparam int STEP_BITS = $clog2(QUOT_BITS);

  localparam int IN_DATA_BITS  = ((ADC_BITS + KEY_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((4 * MV_BITS + 7) / 8) * 8;

  localparam logic [MV_BITS-1:0] FULL_SCALE_RESET = MV_BITS'(5000);

  localparam logic [KEY_BITS-1:0] KEY_RELEASE = KEY_BITS'(14);
  localparam logic [KEY_BITS-1:0] KEY_CLEAR   = KEY_BITS'(15);
  localparam logic [KEY_BITS-1:0] KEY_HOLD    = KEY_BITS'(16);

  // conversion slots, one per result field
  localparam logic [1:0] OP_INSTANT = 2'd0;
  localparam logic [1:0] OP_AVERAGE = 2'd1;
  localparam logic [1:0] OP_MAXIMUM = 2'd2;
  localparam logic [1:0] OP_MINIMUM = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       mul_load;
    logic       div_step;
    logic       store_q;
    logic       out_load;
    logic [1:0] op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/mmmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmmv_ctrl
// sequencer: for each sample runs four multiply/divide conversions through
// the shared datapath, then hands the result to the output register
// ----------------------------------------------------------------------------
module mmmv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mmmv_pkg::status_t status,
  output mmmv_pkg::cmd_t    cmd
);
  import mmmv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state, state_next;
  logic [1:0]           op, op_next;
  logic [STEP_BITS-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_INSTANT;
      step  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    step_next    = step;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.op       = op;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          op_next     = OP_INSTANT;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        step_next    = STEP_BITS'(QUOT_BITS - 1);
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - 1'b1;
        if (step == '0) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store_q = 1'b1;
        if (op == OP_MINIMUM) begin
          state_next = ST_DONE;
        end else begin
          op_next    = op + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mmmv_datapath.sv =====
// ----------------------------------------------------------------------------
// mmmv_datapath
// running statistics, full-scale register, shared multiplier and restoring
// divider, conversion results and the output register
// ----------------------------------------------------------------------------
module mmmv_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [mmmv_pkg::MV_BITS-1:0]            cfg_wdata,
  input  logic [mmmv_pkg::IN_DATA_BITS-1:0]       s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [mmmv_pkg::OUT_DATA_BITS-1:0]      m_tdata,
  output logic                                    m_tuser,
  input  mmmv_pkg::cmd_t                          cmd,
  output mmmv_pkg::status_t                       status
);
  import mmmv_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  logic [MV_BITS-1:0]    full_scale;
  logic [SUM_BITS-1:0]   sum, sum_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [ADC_BITS-1:0]   largest, largest_next;
  logic [ADC_BITS-1:0]   smallest, smallest_next;
  logic                  hold, hold_next;

  logic [ADC_BITS-1:0]   sample;
  logic                  shown;
  logic [ADC_BITS-1:0]   in_sample;
  logic [KEY_BITS-1:0]   in_key;

  logic [PROD_BITS-1:0]  rem;
  logic [PROD_BITS-1:0]  dsh;
  logic [QUOT_BITS-1:0]  quot;
  logic [SUM_BITS-1:0]   mul_a;
  logic [DIVR_BITS-1:0]  divisor;
  logic                  fits;
  logic [MV_BITS-1:0]    res [4];

  assign in_sample = s_tdata[ADC_BITS-1:0];
  assign in_key    = s_tdata[ADC_BITS+KEY_BITS-1:ADC_BITS];

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (cfg_we) begin
      full_scale <= cfg_wdata;
    end
  end

  // clear first, then accumulate unless in hold; hold key acts afterwards
  always_comb begin
    sum_next      = sum;
    count_next    = count;
    largest_next  = largest;
    smallest_next = smallest;
    hold_next     = hold;
    if (in_key == KEY_CLEAR) begin
      sum_next      = '0;
      count_next    = '0;
      largest_next  = '0;
      smallest_next = ADC_BITS'(ADC_MAX_CODE);
    end
    if (!hold) begin
      if (count_next != COUNT_FULL) begin
        sum_next   = sum_next + SUM_BITS'(in_sample);
        count_next = count_next + 1'b1;
      end
      if (in_sample > largest_next) begin
        largest_next = in_sample;
      end
      if (in_sample < smallest_next) begin
        smallest_next = in_sample;
      end
    end
    if (in_key == KEY_HOLD) begin
      hold_next = 1'b1;
    end else if (in_key == KEY_RELEASE) begin
      hold_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      count    <= '0;
      largest  <= '0;
      smallest <= ADC_BITS'(ADC_MAX_CODE);
      hold     <= 1'b0;
    end else if (cmd.load_in) begin
      sum      <= sum_next;
      count    <= count_next;
      largest  <= largest_next;
      smallest <= smallest_next;
      hold     <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample <= in_sample;
      shown  <= !hold;
    end
  end

  // operand and divisor for the current conversion slot
  always_comb begin
    unique case (cmd.op)
      OP_INSTANT: mul_a = SUM_BITS'(sample);
      OP_AVERAGE: mul_a = sum;
      OP_MAXIMUM: mul_a = SUM_BITS'(largest);
      OP_MINIMUM: mul_a = SUM_BITS'(smallest);
      default:    mul_a = '0;
    endcase
    if (cmd.op == OP_AVERAGE) begin
      divisor = DIVR_BITS'(count) * DIVR_BITS'(ADC_MAX_CODE);
    end else begin
      divisor = DIVR_BITS'(ADC_MAX_CODE);
    end
  end

  assign fits = rem >= dsh;

  // restoring division, one quotient bit per step, msb first
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      rem  <= PROD_BITS'(mul_a) * PROD_BITS'(full_scale);
      dsh  <= PROD_BITS'(divisor) << (QUOT_BITS - 1);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QUOT_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_q) begin
      if (cmd.op == OP_AVERAGE && count == '0) begin
        res[cmd.op] <= '0;
      end else begin
        res[cmd.op] <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= shown;
      m_tdata <= OUT_DATA_BITS'({
        shown ? res[OP_MINIMUM] : MV_BITS'(0),
        shown ? res[OP_MAXIMUM] : MV_BITS'(0),
        shown ? res[OP_AVERAGE] : MV_BITS'(0),
        res[OP_INSTANT]});
    end
  end

endmodule

// ===== rtl/core/min_max_mean_voltage_tracker.sv =====
// ----------------------------------------------------------------------------
// min_max_mean_voltage_tracker
// running min / max / mean voltmeter over a stream of ADC samples
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one transfer per ADC period: the sample and the key code.
//   m_* returns one transfer per sample: instant, average, maximum and
//   minimum in millivolts; m_tuser is high when the statistics are shown,
//   low in hold, where average, maximum and minimum read as zero.
//   cfg_we / cfg_wdata write the full-scale millivolt value; write it only
//   while no sample is in flight.
// flow:
//   a sample runs four conversions from input transfer to output valid,
//   each through one shared multiplier and a 13-step restoring divider,
//   then the result is presented. s_tready is high only in the idle state,
//   so a new sample is accepted only after the previous result has been
//   loaded into the output register.
// reset and stalls:
//   rst clears the statistics, leaves hold and sets full scale to 5000 mV.
//   a finished result waits in the output register; the next sample is
//   accepted and converted meanwhile, and waits only at the very end if the
//   previous result has not been taken yet.
// ----------------------------------------------------------------------------
module min_max_mean_voltage_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mmmv_pkg::MV_BITS-1:0]       cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample[9:0], key_code[14:10], zero pad
  input  logic [mmmv_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // instant_mv[12:0], average_mv[25:13], maximum_mv[38:26],
  // minimum_mv[51:39], zero pad
  output logic [mmmv_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // stats_shown[0]
  output logic                               m_tuser
);
  import mmmv_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mmmv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream testbench for the min / max / mean voltage tracker: a directed
// opening, then random samples and key codes under four full-scale settings,
// each reading checked field by field against a running-statistics tracker
// ----------------------------------------------------------------------------
module tb;
  import mmmv_pkg::*;

  localparam longint unsigned MV_LIMIT    = (64'd1 << MV_BITS) - 1;
  localparam longint unsigned COUNT_FULL  = (64'd1 << COUNT_BITS) - 1;
  localparam logic [KEY_BITS-1:0] KEY_NONE = '0;
  localparam int PHASE_ITEMS   = 260;
  localparam int LONG_HOLD_OFF = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [MV_BITS-1:0] instant;
    logic [MV_BITS-1:0] average;
    logic [MV_BITS-1:0] maximum;
    logic [MV_BITS-1:0] minimum;
    logic               shown;
  } reading_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] code;
    logic [KEY_BITS-1:0] key;
  } period_t;

  // running statistics of the meter and the readings still owed by the block
  class meter_tracker;
    logic [MV_BITS-1:0] full_scale;
    longint unsigned    sum;
    longint unsigned    count;
    logic [ADC_BITS-1:0] largest;
    logic [ADC_BITS-1:0] smallest;
    bit                 held;
    reading_t           expected_readings[$];
    int                 taken;
    int                 checked;
    int                 errors;

    function void restart();
      full_scale = FULL_SCALE_RESET;
      held = 1'b0;
      clear_stats();
      expected_readings.delete();
    endfunction

    function void clear_stats();
      sum = 0;
      count = 0;
      largest = '0;
      smallest = ADC_BITS'(ADC_MAX_CODE);
    endfunction

    function logic [MV_BITS-1:0] to_millivolts(longint unsigned raw);
      longint unsigned v;
      v = raw * full_scale / ADC_MAX_CODE;
      return (v > MV_LIMIT) ? MV_LIMIT[MV_BITS-1:0] : v[MV_BITS-1:0];
    endfunction

    function void take_sample(logic [ADC_BITS-1:0] code, logic [KEY_BITS-1:0] key);
      reading_t        r;
      longint unsigned avg;
      if (key == KEY_CLEAR) clear_stats();
      if (!held) begin
        // count full: sum and count freeze, extremes keep tracking
        if (count < COUNT_FULL) begin
          sum += code;
          count++;
        end
        if (code > largest) largest = code;
        if (code < smallest) smallest = code;
      end
      r = '0;
      r.instant = to_millivolts(code);
      if (!held) begin
        avg = 0;
        if (count != 0) avg = sum * full_scale / (ADC_MAX_CODE * count);
        r.average = (avg > MV_LIMIT) ? MV_LIMIT[MV_BITS-1:0] : avg[MV_BITS-1:0];
        r.maximum = to_millivolts(largest);
        r.minimum = to_millivolts(smallest);
        r.shown   = 1'b1;
      end
      if (key == KEY_HOLD) held = 1'b1;
      if (key == KEY_RELEASE) held = 1'b0;
      expected_readings.push_back(r);
      taken++;
    endfunction

    task flag_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at reading %0d: %s got %0d expected %0d",
               checked, what, got, want);
      errors++;
    endtask

    task check_reading(logic [OUT_DATA_BITS-1:0] data, logic user);
      reading_t want;
      if (expected_readings.size() == 0) begin
        flag_mismatch("unexpected transfer, instant_mv", data[MV_BITS-1:0], 0);
      end else begin
        want = expected_readings.pop_front();
        if (data[MV_BITS-1:0] !== want.instant)
          flag_mismatch("instant_mv", data[MV_BITS-1:0], want.instant);
        if (data[2*MV_BITS-1:MV_BITS] !== want.average)
          flag_mismatch("average_mv", data[2*MV_BITS-1:MV_BITS], want.average);
        if (data[3*MV_BITS-1:2*MV_BITS] !== want.maximum)
          flag_mismatch("maximum_mv", data[3*MV_BITS-1:2*MV_BITS], want.maximum);
        if (data[4*MV_BITS-1:3*MV_BITS] !== want.minimum)
          flag_mismatch("minimum_mv", data[4*MV_BITS-1:3*MV_BITS], want.minimum);
        if (user !== want.shown)
          flag_mismatch("stats_shown", user, want.shown);
      end
      checked++;
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [MV_BITS-1:0]       cfg_wdata = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tuser;

  meter_tracker meter = new();
  bit           steady = 1'b0;
  bit           hold_off_req = 1'b0;
  int           cycles = 0;

  min_max_mean_voltage_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) meter.check_reading(m_tdata, m_tuser);
  end

  // receiver: random backpressure, none while steady, one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD_OFF;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer_period(input period_t p);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'({p.key, p.code});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    meter.take_sample(p.code, p.key);
    @(negedge clk);
  endtask

  task automatic write_full_scale(input logic [MV_BITS-1:0] mv);
    cfg_we    <= 1'b1;
    cfg_wdata <= mv;
    @(negedge clk);
    cfg_we    <= 1'b0;
    meter.full_scale = mv;
    @(negedge clk);
  endtask

  task automatic wait_for_readings();
    while (meter.expected_readings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic period_t random_period();
    period_t p;
    int      r;
    r = $urandom_range(99);
    if (r < 66)      p.key = KEY_NONE;
    else if (r < 72) p.key = KEY_CLEAR;
    else if (r < 78) p.key = KEY_HOLD;
    else if (r < 85) p.key = KEY_RELEASE;
    else if (r < 93) p.key = KEY_BITS'($urandom_range(1, 13));
    else             p.key = KEY_BITS'($urandom_range(17, 31));
    r = $urandom_range(99);
    if (r < 5)       p.code = '0;
    else if (r < 10) p.code = ADC_BITS'(ADC_MAX_CODE);
    else if (r < 15) p.code = ADC_BITS'($urandom_range(0, 15));
    else if (r < 20) p.code = ADC_BITS'($urandom_range(1008, 1023));
    else             p.code = ADC_BITS'($urandom_range(0, 1023));
    return p;
  endfunction

  initial begin
    period_t             opening[$];
    logic [MV_BITS-1:0]  settings[4];
    meter.restart();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, the clear, hold and release keys, other key codes and the hold sequences at the reset full scale
    opening = '{
      '{10'd0,    KEY_NONE},    '{10'd1023, KEY_NONE},    '{10'd512,  5'd17},
      '{10'd1,    5'd31},       '{10'd700,  5'd13},       '{10'd300,  KEY_HOLD},
      '{10'd1023, KEY_NONE},    '{10'd5,    KEY_CLEAR},   '{10'd800,  KEY_RELEASE},
      '{10'd1000, KEY_NONE},    '{10'd0,    KEY_CLEAR},   '{10'd1023, KEY_HOLD},
      '{10'd200,  KEY_HOLD},    '{10'd200,  KEY_RELEASE}, '{10'd1023, 5'd1},
      '{10'd341,  5'd8},        '{10'd682,  5'd2},        '{10'd1022, 5'd4},
      '{10'd1023, KEY_CLEAR},   '{10'd1023, KEY_NONE},    '{10'd0,    5'd30}
    };
    foreach (opening[i]) offer_period(opening[i]);

    settings = '{MV_BITS'(1000), MV_BITS'(5500), MV_BITS'($urandom_range(1000, 5500)),
                 MV_BITS'(ADC_MAX_CODE)};
    foreach (settings[ph]) begin
      s_tvalid <= 1'b0;
      wait_for_readings();
      repeat (4) @(negedge clk);
      write_full_scale(settings[ph]);
      steady = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) hold_off_req = 1'b1;
        offer_period(random_period());
      end
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    wait_for_readings();
    repeat (70) @(posedge clk);
    if (meter.expected_readings.size() != 0)
      meter.flag_mismatch("readings never delivered", meter.expected_readings.size(), 0);
    if (meter.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
